// ----- design/swrm_pkg.sv -----
// shared types and constants of the sliding window rate meter
package swrm_pkg;

    localparam int TIME_W    = 32;
    localparam int VAL_W     = 32;
    localparam int RATE_W    = 48;
    localparam int TOTAL_W   = 64;
    localparam int COUNT_W   = 7;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 32;

    localparam int DIV_STEPS = RATE_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [RATE_W-1:0] RATE_MAX = '1;

    localparam logic [CFG_W-1:0] RATE_WINDOW_RST    = 32'd1000000;
    localparam logic [CFG_W-1:0] ROLLING_WINDOW_RST = 32'd10000000;

    // request opcodes
    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RATE_WINDOW    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROLLING_WINDOW = 1'd1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DROP,
        S_WRITE,
        S_TRIM_WAIT,
        S_TRIM_CHK,
        S_Q_CHK,
        S_Q_MUL1,
        S_Q_MUL2,
        S_Q_SAT,
        S_Q_DIV,
        S_Q_OUT
    } t_state;

    typedef struct packed {
        logic capture;
        logic drop;
        logic set_flag;
        logic write;
        logic el_load;
        logic rate_zero;
        logic rate_max;
        logic mul1;
        logic mul2;
        logic div_init;
        logic div_step;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic in_query;
        logic full;
        logic empty;
        logic early;
        logic trim_hit;
        logic no_elapsed;
        logic rate_sat;
        logic div_last;
    } t_dp_sts;

endpackage

// ----- design/swrm_in_if.sv -----
// request channel carrying one add or query
interface swrm_in_if import swrm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              op;
    logic [TIME_W-1:0] timestamp;
    logic [VAL_W-1:0]  sample_value;

    modport source (output valid, output op, output timestamp, output sample_value,
                    input ready);
    modport sink   (input valid, input op, input timestamp, input sample_value,
                    output ready);
endinterface

// ----- design/swrm_out_if.sv -----
// result channel carrying one query answer
interface swrm_out_if import swrm_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [RATE_W-1:0]  average_rate;
    logic [TOTAL_W-1:0] lifetime_total;
    logic [COUNT_W-1:0] sample_count;
    logic               samples_dropped;

    modport source (output valid, output average_rate, output lifetime_total,
                    output sample_count, output samples_dropped, input ready);
    modport sink   (input valid, input average_rate, input lifetime_total,
                    input sample_count, input samples_dropped, output ready);
endinterface

// ----- design/swrm_cfg_if.sv -----
// configuration write channel
interface swrm_cfg_if import swrm_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- design/swrm_ram.sv -----
// generic single write port ram with registered read
module swrm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- design/swrm_ctrl.sv -----
// sequencer for adds, trimming and the query division
module swrm_ctrl import swrm_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);
    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_out_free;

    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_sts.in_query) begin
                        n_state = S_Q_CHK;
                    end else if (i_sts.full) begin
                        n_state = S_DROP;
                    end else begin
                        n_state = S_WRITE;
                    end
                end
            end
            S_DROP:      n_state = S_WRITE;
            S_WRITE:     n_state = i_sts.early ? S_IDLE : S_TRIM_WAIT;
            S_TRIM_WAIT: n_state = S_TRIM_CHK;
            S_TRIM_CHK: begin
                n_state = (!i_sts.empty && i_sts.trim_hit) ? S_TRIM_WAIT : S_IDLE;
            end
            S_Q_CHK: begin
                n_state = (i_sts.empty || i_sts.no_elapsed) ? S_Q_OUT : S_Q_MUL1;
            end
            S_Q_MUL1: n_state = S_Q_MUL2;
            S_Q_MUL2: n_state = S_Q_SAT;
            S_Q_SAT:  n_state = i_sts.rate_sat ? S_Q_OUT : S_Q_DIV;
            S_Q_DIV:  n_state = i_sts.div_last ? S_Q_OUT : S_Q_DIV;
            S_Q_OUT:  n_state = w_out_free ? S_IDLE : S_Q_OUT;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            S_DROP: begin
                o_cmd.drop     = 1'b1;
                o_cmd.set_flag = 1'b1;
            end
            S_WRITE:    o_cmd.write = 1'b1;
            S_TRIM_CHK: o_cmd.drop  = !i_sts.empty && i_sts.trim_hit;
            S_Q_CHK: begin
                if (i_sts.empty) begin
                    o_cmd.rate_zero = 1'b1;
                end else if (i_sts.no_elapsed) begin
                    o_cmd.rate_max = 1'b1;
                end else begin
                    o_cmd.el_load = 1'b1;
                end
            end
            S_Q_MUL1: o_cmd.mul1 = 1'b1;
            S_Q_MUL2: o_cmd.mul2 = 1'b1;
            S_Q_SAT: begin
                o_cmd.rate_max = i_sts.rate_sat;
                o_cmd.div_init = !i_sts.rate_sat;
            end
            S_Q_DIV: o_cmd.div_step = 1'b1;
            S_Q_OUT: o_cmd.out_load = w_out_free;
            default: ;
        endcase
    end

    // result register holds until taken, then frees for the next query
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
endmodule

// ----- design/swrm_dp.sv -----
// sample ring, window sums, rate multiply and serial divider
module swrm_dp import swrm_pkg::*; #(
    parameter int DEPTH = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_cmd,
    output t_dp_sts              o_sts,
    input  logic                 i_op,
    input  logic [TIME_W-1:0]    i_timestamp,
    input  logic [VAL_W-1:0]     i_sample_value,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output logic [RATE_W-1:0]    o_average_rate,
    output logic [TOTAL_W-1:0]   o_lifetime_total,
    output logic [COUNT_W-1:0]   o_sample_count,
    output logic                 o_samples_dropped
);
    localparam int IdxW  = $clog2(DEPTH);
    localparam int CntW  = $clog2(DEPTH + 1);
    localparam int SlotW = CntW + 1;
    localparam int SumW  = VAL_W + $clog2(DEPTH);
    localparam int HiW   = SumW - 32;
    localparam int NumW  = SumW + 32;
    localparam int TopW  = NumW - RATE_W;
    localparam int CmpW  = (TopW > TIME_W) ? TopW : TIME_W;
    localparam int WordW = TIME_W + VAL_W;

    // control state
    logic [CFG_W-1:0]   r_rate_win;
    logic [CFG_W-1:0]   r_roll_win;
    logic [IdxW-1:0]    r_oldest;
    logic [CntW-1:0]    r_held;
    logic [SumW-1:0]    r_sum;
    logic [TOTAL_W-1:0] r_life;
    logic               r_flag;

    // working registers
    logic [TIME_W-1:0]    r_ts;
    logic [VAL_W-1:0]     r_val;
    logic [TIME_W-1:0]    r_thr;
    logic [TIME_W-1:0]    r_el;
    logic [63:0]          r_plo;
    logic [NumW-1:0]      r_num;
    logic [TIME_W-1:0]    r_rem;
    logic [RATE_W-1:0]    r_quo;
    logic [DIV_CNT_W-1:0] r_cnt;

    // result register
    logic [RATE_W-1:0]  r_out_rate;
    logic [TOTAL_W-1:0] r_out_total;
    logic [COUNT_W-1:0] r_out_count;
    logic               r_out_dropped;

    logic [WordW-1:0]     w_rdata;
    logic [TIME_W-1:0]    w_rd_time;
    logic [VAL_W-1:0]     w_rd_amt;
    logic [SlotW-1:0]     w_slot_sum;
    logic [IdxW-1:0]      w_slot;
    logic [IdxW-1:0]      w_oldest_nxt;
    logic [TOTAL_W:0]     w_life_sum;
    logic [HiW+31:0]      w_phi;
    logic [TopW-1:0]      w_top;
    logic [TIME_W:0]      w_div_t;
    logic [TIME_W:0]      w_div_diff;
    logic                 w_div_ge;

    assign w_rd_time = w_rdata[WordW-1:VAL_W];
    assign w_rd_amt  = w_rdata[VAL_W-1:0];

    // newest slot sits held entries past the oldest, wrapping at the ring size
    assign w_slot_sum = SlotW'(r_oldest) + SlotW'(r_held);
    assign w_slot     = (w_slot_sum >= SlotW'(DEPTH)) ? IdxW'(w_slot_sum - SlotW'(DEPTH))
                                                      : IdxW'(w_slot_sum);
    assign w_oldest_nxt = (r_oldest == IdxW'(DEPTH - 1)) ? '0 : r_oldest + IdxW'(1);

    assign w_life_sum = {1'b0, r_life} + (TOTAL_W + 1)'(r_val);

    assign w_phi = (HiW + 32)'(r_sum[SumW-1:32]) * (HiW + 32)'(r_rate_win);
    assign w_top = r_num[NumW-1:RATE_W];

    assign w_div_t    = {r_rem, r_quo[RATE_W-1]};
    assign w_div_ge   = w_div_t >= {1'b0, r_el};
    assign w_div_diff = w_div_t - {1'b0, r_el};

    swrm_ram #(
        .WIDTH (WordW),
        .DEPTH (DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (i_cmd.write),
        .i_waddr (w_slot),
        .i_wdata ({r_ts, r_val}),
        .i_raddr (r_oldest),
        .o_rdata (w_rdata)
    );

    always_comb begin
        o_sts            = '0;
        o_sts.in_query   = (i_op == OP_QUERY);
        o_sts.full       = (r_held == CntW'(DEPTH));
        o_sts.empty      = (r_held == '0);
        o_sts.early      = (r_ts < r_roll_win);
        o_sts.trim_hit   = (w_rd_time < r_thr);
        o_sts.no_elapsed = (r_ts <= w_rd_time);
        // quotient reaches 2^48 exactly when the top bits are not below the divisor
        o_sts.rate_sat   = (CmpW'(w_top) >= CmpW'(r_el));
        o_sts.div_last   = (r_cnt == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate_win <= RATE_WINDOW_RST;
            r_roll_win <= ROLLING_WINDOW_RST;
            r_oldest   <= '0;
            r_held     <= '0;
            r_sum      <= '0;
            r_life     <= '0;
            r_flag     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_RATE_WINDOW:    r_rate_win <= i_cfg_data;
                    REG_ROLLING_WINDOW: r_roll_win <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.drop) begin
                r_sum    <= r_sum - SumW'(w_rd_amt);
                r_oldest <= w_oldest_nxt;
                r_held   <= r_held - CntW'(1);
            end else if (i_cmd.write) begin
                r_sum  <= r_sum + SumW'(r_val);
                r_held <= r_held + CntW'(1);
            end
            if (i_cmd.write) begin
                r_life <= w_life_sum[TOTAL_W] ? '1 : w_life_sum[TOTAL_W-1:0];
            end
            if (i_cmd.set_flag) begin
                r_flag <= 1'b1;
            end else if (i_cmd.out_load) begin
                r_flag <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_ts  <= i_timestamp;
            r_val <= i_sample_value;
        end
        if (i_cmd.write) begin
            r_thr <= r_ts - r_roll_win;
        end
        if (i_cmd.el_load) begin
            r_el <= r_ts - w_rd_time;
        end
        if (i_cmd.mul1) begin
            r_plo <= 64'(r_sum[31:0]) * 64'(r_rate_win);
        end
        if (i_cmd.mul2) begin
            r_num <= NumW'(r_plo) + {w_phi, 32'b0};
        end
        if (i_cmd.rate_zero) begin
            r_quo <= '0;
        end else if (i_cmd.rate_max) begin
            r_quo <= RATE_MAX;
        end else if (i_cmd.div_init) begin
            r_quo <= r_num[RATE_W-1:0];
            r_rem <= TIME_W'(w_top);
            r_cnt <= DIV_CNT_W'(DIV_STEPS - 1);
        end else if (i_cmd.div_step) begin
            // restoring step: one quotient bit per cycle
            r_quo <= {r_quo[RATE_W-2:0], w_div_ge};
            r_rem <= w_div_ge ? w_div_diff[TIME_W-1:0] : w_div_t[TIME_W-1:0];
            r_cnt <= r_cnt - DIV_CNT_W'(1);
        end
        if (i_cmd.out_load) begin
            r_out_rate    <= r_quo;
            r_out_total   <= r_life;
            r_out_count   <= COUNT_W'(r_held);
            r_out_dropped <= r_flag;
        end
    end

    assign o_average_rate    = r_out_rate;
    assign o_lifetime_total  = r_out_total;
    assign o_sample_count    = r_out_count;
    assign o_samples_dropped = r_out_dropped;
endmodule

// ----- design/sliding_window_rate_meter.sv -----
// Sliding window rate meter: each add request stores a timestamped amount in a
// ring of DEPTH entries (dropping the oldest and raising a sticky flag when the
// ring is full), adds it to the window sum and to a saturating lifetime total,
// and then trims from the oldest end every sample older than timestamp minus
// rolling_window. Each query request returns floor(window_sum * rate_window /
// (timestamp - oldest time)) saturated to 48 bits (0 on an empty ring, all ones
// with no elapsed time), the lifetime total, the held count and the drop flag,
// which the query clears. One request is in work at a time. An add skips the
// trim when timestamp is below rolling_window, takes an extra drop step when
// the ring is full, and spends a wait and a check on each trimmed sample,
// since each trim check waits on the registered ring read of the new oldest
// entry. A query runs the 48-step restoring divider that retires one quotient
// bit a cycle, skipping it on an empty ring, with no elapsed time or when the
// product already saturates, and then waits until the previous result is
// taken. Configuration writes are taken at any time and must land while no
// request is in work.
module sliding_window_rate_meter import swrm_pkg::*; #(
    parameter int DEPTH = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    swrm_in_if.sink    i_in,
    swrm_out_if.source o_out,
    swrm_cfg_if.sink   i_cfg
);
    t_dp_cmd w_cmd;
    t_dp_sts w_sts;
    logic    w_in_ready;
    logic    w_out_valid;

    swrm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_out.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    swrm_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts),
        .i_op              (i_in.op),
        .i_timestamp       (i_in.timestamp),
        .i_sample_value    (i_in.sample_value),
        .i_cfg_we          (i_cfg.valid),
        .i_cfg_index       (i_cfg.index),
        .i_cfg_data        (i_cfg.data),
        .o_average_rate    (o_out.average_rate),
        .o_lifetime_total  (o_out.lifetime_total),
        .o_sample_count    (o_out.sample_count),
        .o_samples_dropped (o_out.samples_dropped)
    );

    assign i_in.ready  = w_in_ready;
    assign o_out.valid = w_out_valid;
    assign i_cfg.ready = 1'b1;
endmodule
